// File: design/assert_macros.svh
// assertion macros used by the frame sender design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/twdfs_pkg.sv
// types and constants of the two-wire display frame sender
`timescale 1ns / 1ps

package twdfs_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] PART_IDLE = 2'd0;
    localparam logic [1:0] PART_DATA = 2'd1;
    localparam logic [1:0] PART_ADDR = 2'd2;
    localparam logic [1:0] PART_CTRL = 2'd3;

    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_DISPLAY_ON = 1'b1;

    localparam logic [7:0] CMD_DATA    = 8'h40;
    localparam logic [7:0] CMD_ADDR    = 8'hC0;
    localparam logic [7:0] CMD_CTRL    = 8'h80;
    localparam logic [7:0] CTRL_ON     = 8'h08;
    localparam logic [7:0] CTRL_BRIGHT = 8'h07;

    localparam logic [4:0] BIT_STEPS = 5'd24;
    localparam logic [4:0] ACK_CLK   = 5'd24;
    localparam logic [4:0] ACK_LOW   = 5'd25;
    localparam logic [4:0] ACK_SENSE = 5'd26;
    localparam logic [4:0] LAST_STEP = 5'd27;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] digit_index;
        logic [7:0] segment_bits;
        logic       dio_sense;
    } req_t;

    typedef struct packed {
        logic clk_low;
        logic dio_low;
        logic busy_res;
        logic nack_seen;
    } rsp_t;

endpackage

// File: design/twdfs_req_if.sv
// input channel of the frame sender
`timescale 1ns / 1ps

interface twdfs_req_if;
    logic              valid;
    logic              ready;
    twdfs_pkg::req_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/twdfs_rsp_if.sv
// result channel of the frame sender
`timescale 1ns / 1ps

interface twdfs_rsp_if;
    logic              valid;
    logic              ready;
    twdfs_pkg::rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/two_wire_display_frame_sender.sv
// Two-wire display frame sender. Holds one segment byte per digit and
// sends a three-part frame (data command, address command plus digit
// bytes, control byte) over an open-drain clock/data link, one delay step
// per tick word. Every accepted word yields one result word with the wire
// drives and the busy and missing-acknowledge flags. A word is taken every
// clock cycle: the sequencer registers update in the cycle of acceptance
// and the result sits in an output register backed by a one-word skid
// register, so input stalls only once both are full. The user must write
// brightness and display-on via the configuration port only while idle, as
// the block does not check it; the control byte takes them at the third part.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module two_wire_display_frame_sender #(
    parameter int DIGITS = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [2:0]           cfg_data,
    twdfs_req_if.sink            req,
    twdfs_rsp_if.source          rsp
);

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [2:0] NUM_DIGITS  = 3'(DIGITS);
    localparam logic [2:0] PART2_BYTES = 3'(DIGITS + 1);

    typedef enum logic [1:0] {
        PH_START,
        PH_BYTE,
        PH_STOP
    } phase_t;

    logic [2:0]       brightness_reg;
    logic             display_on_reg;
    logic [7:0]       store_reg [DIGITS];
    logic [1:0]       part_reg, part_next;
    phase_t           phase_reg, phase_next;
    logic [2:0]       byte_count_reg, byte_count_next;
    logic [4:0]       step_reg, step_next;
    logic [1:0]       bit_phase_reg, bit_phase_next;
    logic [7:0]       shift_reg, shift_next;
    logic             clk_drive_reg, clk_drive_next;
    logic             dio_drive_reg, dio_drive_next;
    logic             nack_reg, nack_next;

    logic             out_valid_reg;
    twdfs_pkg::rsp_t  out_data_reg;
    logic             skid_valid_reg;
    twdfs_pkg::rsp_t  skid_data_reg;

    logic             accept;
    logic             out_free;
    logic             busy;
    logic             store_we;
    logic [2:0]       byte_inc;
    logic [2:0]       part_bytes;
    logic [7:0]       ctrl_byte;
    logic [7:0]       first_byte;
    logic [7:0]       store_rd;
    twdfs_pkg::rsp_t  result;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign busy     = part_reg != twdfs_pkg::PART_IDLE;

    assign req.ready = !skid_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign byte_inc   = byte_count_reg + 3'd1;
    assign part_bytes = (part_reg == twdfs_pkg::PART_ADDR) ? PART2_BYTES : 3'd1;
    assign ctrl_byte  = twdfs_pkg::CMD_CTRL
                      | ({5'd0, brightness_reg} & twdfs_pkg::CTRL_BRIGHT)
                      | (display_on_reg ? twdfs_pkg::CTRL_ON : 8'h00);
    assign store_rd   = store_reg[IDX_W'(byte_inc - 3'd1)];

    always_comb
    begin
        case (part_reg)
            twdfs_pkg::PART_DATA: first_byte = twdfs_pkg::CMD_DATA;
            twdfs_pkg::PART_CTRL: first_byte = ctrl_byte;
            default:              first_byte = twdfs_pkg::CMD_ADDR;
        endcase
    end

    always_comb
    begin
        part_next       = part_reg;
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        step_next       = step_reg;
        bit_phase_next  = bit_phase_reg;
        shift_next      = shift_reg;
        clk_drive_next  = clk_drive_reg;
        dio_drive_next  = dio_drive_reg;
        nack_next       = nack_reg;
        store_we        = 1'b0;

        if (accept)
        begin
            unique case (req.data.op)
                twdfs_pkg::OP_LOAD:
                begin
                    store_we = !busy && (req.data.digit_index < NUM_DIGITS);
                end
                twdfs_pkg::OP_BEGIN:
                begin
                    if (!busy)
                    begin
                        part_next       = twdfs_pkg::PART_DATA;
                        phase_next      = PH_START;
                        byte_count_next = 3'd0;
                        step_next       = 5'd0;
                        bit_phase_next  = 2'd0;
                        nack_next       = 1'b0;
                    end
                end
                twdfs_pkg::OP_TICK:
                begin
                    if (busy)
                    begin
                        unique case (phase_reg)
                            PH_START:
                            begin
                                dio_drive_next  = 1'b1;
                                phase_next      = PH_BYTE;
                                byte_count_next = 3'd0;
                                step_next       = 5'd0;
                                bit_phase_next  = 2'd0;
                                shift_next      = first_byte;
                            end
                            PH_BYTE:
                            begin
                                if (step_reg < twdfs_pkg::BIT_STEPS)
                                begin
                                    case (bit_phase_reg)
                                        2'd0: clk_drive_next = 1'b1;
                                        2'd1: dio_drive_next = !shift_reg[0];
                                        2'd2:
                                        begin
                                            clk_drive_next = 1'b0;
                                            shift_next     = {1'b0, shift_reg[7:1]};
                                        end
                                        default: ;
                                    endcase
                                    step_next      = step_reg + 5'd1;
                                    bit_phase_next = (bit_phase_reg == 2'd2) ? 2'd0
                                                   : bit_phase_reg + 2'd1;
                                end
                                else if (step_reg == twdfs_pkg::ACK_CLK)
                                begin
                                    clk_drive_next = 1'b1;
                                    dio_drive_next = 1'b0;
                                    step_next      = twdfs_pkg::ACK_LOW;
                                end
                                else if (step_reg == twdfs_pkg::ACK_LOW)
                                begin
                                    clk_drive_next = 1'b0;
                                    step_next      = twdfs_pkg::ACK_SENSE;
                                end
                                else if (step_reg == twdfs_pkg::ACK_SENSE)
                                begin
                                    if (!req.data.dio_sense)
                                        dio_drive_next = 1'b1;
                                    else
                                        nack_next = 1'b1;
                                    step_next = twdfs_pkg::LAST_STEP;
                                end
                                else
                                begin
                                    clk_drive_next  = 1'b1;
                                    step_next       = 5'd0;
                                    bit_phase_next  = 2'd0;
                                    byte_count_next = byte_inc;
                                    if (byte_inc < part_bytes && byte_inc != 3'd0)
                                        shift_next = store_rd;
                                    else
                                        phase_next = PH_STOP;
                                end
                            end
                            PH_STOP:
                            begin
                                if (step_reg == 5'd0)
                                begin
                                    dio_drive_next = 1'b1;
                                    step_next      = 5'd1;
                                end
                                else if (step_reg == 5'd1)
                                begin
                                    clk_drive_next = 1'b0;
                                    step_next      = 5'd2;
                                end
                                else
                                begin
                                    dio_drive_next  = 1'b0;
                                    step_next       = 5'd0;
                                    byte_count_next = 3'd0;
                                    phase_next      = PH_START;
                                    part_next       = (part_reg == twdfs_pkg::PART_CTRL)
                                                    ? twdfs_pkg::PART_IDLE
                                                    : part_reg + 2'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign result.clk_low   = clk_drive_next;
    assign result.dio_low   = dio_drive_next;
    assign result.busy_res  = part_next != twdfs_pkg::PART_IDLE;
    assign result.nack_seen = nack_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 3'd7;
            display_on_reg <= 1'b1;
            for (int i = 0; i < DIGITS; i++)
                store_reg[i] <= 8'h00;
            part_reg       <= twdfs_pkg::PART_IDLE;
            phase_reg      <= PH_START;
            byte_count_reg <= 3'd0;
            step_reg       <= 5'd0;
            bit_phase_reg  <= 2'd0;
            shift_reg      <= 8'h00;
            clk_drive_reg  <= 1'b0;
            dio_drive_reg  <= 1'b0;
            nack_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    twdfs_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_data;
                    twdfs_pkg::REG_DISPLAY_ON: display_on_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (store_we)
                store_reg[IDX_W'(req.data.digit_index)] <= req.data.segment_bits;

            part_reg       <= part_next;
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            step_reg       <= step_next;
            bit_phase_reg  <= bit_phase_next;
            shift_reg      <= shift_next;
            clk_drive_reg  <= clk_drive_next;
            dio_drive_reg  <= dio_drive_next;
            nack_reg       <= nack_next;

            // result register with one skid word behind it
            if (accept)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= result;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                    skid_data_reg  <= result;
                end
            end
            else if (rsp.ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `ASSERT_NEXT(a_skid_on_stall, accept && out_valid_reg && !rsp.ready, skid_valid_reg)
    `ASSERT_IMPL(a_idle_released, part_reg == twdfs_pkg::PART_IDLE, !clk_drive_reg && !dio_drive_reg && phase_reg == PH_START)
    `ASSERT_ALWAYS(a_step_range, step_reg <= twdfs_pkg::LAST_STEP && bit_phase_reg != 2'd3)
    `ASSERT_IMPL(a_stop_steps, phase_reg == PH_STOP, step_reg <= 5'd2)

endmodule

// File: tb/tb_two_wire_display_frame_sender.sv
// self-checking testbench for the two-wire display frame sender
`timescale 1ns / 1ps

module tb_two_wire_display_frame_sender;

    localparam int DIGITS = 5;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int FRAME_TICKS = 12 + (DIGITS + 3) * 28;
    localparam int PHASE_WORDS = 145;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [1:0] {SEQ_START, SEQ_BYTE, SEQ_STOP} seq_phase_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic       cfg_index;
    logic [2:0] cfg_data;

    twdfs_req_if req_ch();
    twdfs_rsp_if rsp_ch();

    two_wire_display_frame_sender #(
        .DIGITS(DIGITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    always #1 clk = ~clk;

    twdfs_pkg::req_t pending_words[$];
    twdfs_pkg::rsp_t expected_wires[$];
    int   send_gap_pct = 0;
    int   recv_gap_pct = 0;
    int   hold_ask = 0;
    int   hold_seen;
    int   hold_left;
    int   quiet_cycles = 0;
    int   failures = 0;

    // generator view of the frame, used only to shape the stimulus
    int   frame_ticks_left = 0;
    int   queued_words = 0;

    // predicted state of the sender
    logic [7:0] digits_held [DIGITS];
    logic [1:0] part_now;
    seq_phase_t phase_now;
    logic [2:0] byte_no;
    logic [4:0] step_no;
    logic [7:0] shifting;
    logic       clk_pull;
    logic       dio_pull;
    logic       ack_missed;
    logic [2:0] bright_reg;
    logic       on_reg;

    function automatic logic [7:0] part_byte(logic [2:0] k);
        if (part_now == twdfs_pkg::PART_DATA)
            return twdfs_pkg::CMD_DATA;
        if (part_now == twdfs_pkg::PART_CTRL)
            return twdfs_pkg::CMD_CTRL | ({5'd0, bright_reg} & twdfs_pkg::CTRL_BRIGHT)
                 | (on_reg ? twdfs_pkg::CTRL_ON : 8'h00);
        if (k == 3'd0)
            return twdfs_pkg::CMD_ADDR;
        if (int'(k) - 1 < DIGITS)
            return digits_held[k - 3'd1];
        return 8'h00;
    endfunction

    function automatic void advance_wires(logic sense);
        int bytes_in;
        bytes_in = (part_now == twdfs_pkg::PART_ADDR) ? 1 + DIGITS : 1;
        if (part_now == twdfs_pkg::PART_IDLE)
            return;
        case (phase_now)
            SEQ_START:
            begin
                dio_pull = 1'b1;
                phase_now = SEQ_BYTE;
                byte_no = 3'd0;
                step_no = 5'd0;
                shifting = part_byte(3'd0);
            end
            SEQ_BYTE:
            begin
                if (step_no < twdfs_pkg::BIT_STEPS)
                begin
                    case (step_no % 5'd3)
                        5'd0: clk_pull = 1'b1;
                        5'd1: dio_pull = ~shifting[0];
                        default:
                        begin
                            clk_pull = 1'b0;
                            shifting = shifting >> 1;
                        end
                    endcase
                    step_no = step_no + 5'd1;
                end
                else if (step_no == twdfs_pkg::ACK_CLK)
                begin
                    clk_pull = 1'b1;
                    dio_pull = 1'b0;
                    step_no = twdfs_pkg::ACK_LOW;
                end
                else if (step_no == twdfs_pkg::ACK_LOW)
                begin
                    clk_pull = 1'b0;
                    step_no = twdfs_pkg::ACK_SENSE;
                end
                else if (step_no == twdfs_pkg::ACK_SENSE)
                begin
                    if (!sense)
                        dio_pull = 1'b1;
                    else
                        ack_missed = 1'b1;
                    step_no = twdfs_pkg::LAST_STEP;
                end
                else
                begin
                    clk_pull = 1'b1;
                    step_no = 5'd0;
                    byte_no = byte_no + 3'd1;
                    if (int'(byte_no) < bytes_in && byte_no != 3'd0)
                        shifting = part_byte(byte_no);
                    else
                        phase_now = SEQ_STOP;
                end
            end
            default:
            begin
                if (step_no == 5'd0)
                begin
                    dio_pull = 1'b1;
                    step_no = 5'd1;
                end
                else if (step_no == 5'd1)
                begin
                    clk_pull = 1'b0;
                    step_no = 5'd2;
                end
                else
                begin
                    dio_pull = 1'b0;
                    step_no = 5'd0;
                    byte_no = 3'd0;
                    phase_now = SEQ_START;
                    part_now = (part_now == twdfs_pkg::PART_CTRL) ? twdfs_pkg::PART_IDLE
                                                                 : part_now + 2'd1;
                end
            end
        endcase
    endfunction

    function automatic twdfs_pkg::rsp_t predict_wires(twdfs_pkg::req_t w);
        twdfs_pkg::rsp_t r;
        logic busy;
        busy = part_now != twdfs_pkg::PART_IDLE;
        case (w.op)
            twdfs_pkg::OP_LOAD:
                if (!busy && w.digit_index < DIGITS)
                    digits_held[w.digit_index] = w.segment_bits;
            twdfs_pkg::OP_BEGIN:
                if (!busy)
                begin
                    part_now = twdfs_pkg::PART_DATA;
                    phase_now = SEQ_START;
                    byte_no = 3'd0;
                    step_no = 5'd0;
                    ack_missed = 1'b0;
                end
            twdfs_pkg::OP_TICK:
                advance_wires(w.dio_sense);
            default: ;
        endcase
        r.clk_low = clk_pull;
        r.dio_low = dio_pull;
        r.busy_res = part_now != twdfs_pkg::PART_IDLE;
        r.nack_seen = ack_missed;
        return r;
    endfunction

    task automatic queue_word(logic [1:0] op, logic [2:0] idx, logic [7:0] seg, logic sense);
        twdfs_pkg::req_t w;
        w.op = op;
        w.digit_index = idx;
        w.segment_bits = seg;
        w.dio_sense = sense;
        pending_words.push_back(w);
        queued_words++;
        case (op)
            twdfs_pkg::OP_BEGIN:
                if (frame_ticks_left == 0)
                    frame_ticks_left = FRAME_TICKS;
            twdfs_pkg::OP_TICK:
                if (frame_ticks_left > 0)
                    frame_ticks_left--;
            default: ;
        endcase
    endtask

    task automatic tick_word();
        queue_word(twdfs_pkg::OP_TICK, 3'($urandom), 8'($urandom),
                   $urandom_range(0, 6) == 0);
    endtask

    task automatic noise_word();
        queue_word(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic load_word();
        logic [2:0] idx;
        if ($urandom_range(0, 9) < 8)
            idx = 3'($urandom_range(0, DIGITS - 1));
        else
            idx = 3'($urandom_range(DIGITS, 7));
        queue_word(twdfs_pkg::OP_LOAD, idx, 8'($urandom), 1'($urandom));
    endtask

    // tick on, with the odd stray word, until the frame in progress ends
    task automatic finish_frame();
        while (frame_ticks_left > 0)
        begin
            if ($urandom_range(0, 11) == 0)
                noise_word();
            else
                tick_word();
        end
    endtask

    // about target words; a frame may run on into the next stretch
    task automatic random_phase(int target);
        int first;
        first = queued_words;
        while (queued_words - first < target)
        begin
            if (frame_ticks_left > 0)
            begin
                if ($urandom_range(0, 11) == 0)
                    noise_word();
                else
                    tick_word();
            end
            else
            begin
                repeat ($urandom_range(0, 6))
                    load_word();
                if ($urandom_range(0, 3) == 0)
                    noise_word();
                queue_word(twdfs_pkg::OP_BEGIN, 3'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || req_ch.valid || expected_wires.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_setting(logic [2:0] level, logic on);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= twdfs_pkg::REG_BRIGHTNESS;
        cfg_data <= level;
        @(posedge clk);
        cfg_index <= twdfs_pkg::REG_DISPLAY_ON;
        cfg_data <= {2'b00, on};
        @(posedge clk);
        cfg_we <= 1'b0;
        bright_reg = level;
        on_reg = on;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_wires.push_back(predict_wires(req_ch.data));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data <= pending_words.pop_front();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        twdfs_pkg::rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_wires.size() == 0)
                begin
                    $error("result word with nothing expected");
                    failures++;
                end
                else
                begin
                    want = expected_wires.pop_front();
                    if (rsp_ch.data.clk_low !== want.clk_low)
                    begin
                        $error("clk_low: expected %0b, got %0b", want.clk_low,
                               rsp_ch.data.clk_low);
                        failures++;
                    end
                    if (rsp_ch.data.dio_low !== want.dio_low)
                    begin
                        $error("dio_low: expected %0b, got %0b", want.dio_low,
                               rsp_ch.data.dio_low);
                        failures++;
                    end
                    if (rsp_ch.data.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0b, got %0b", want.busy_res,
                               rsp_ch.data.busy_res);
                        failures++;
                    end
                    if (rsp_ch.data.nack_seen !== want.nack_seen)
                    begin
                        $error("nack_seen: expected %0b, got %0b", want.nack_seen,
                               rsp_ch.data.nack_seen);
                        failures++;
                    end
                end
            end
            if (hold_seen != hold_ask)
            begin
                hold_seen <= hold_ask;
                hold_left <= HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= $urandom_range(0, 99) >= recv_gap_pct;
        end
    end

    // watchdog on words moving at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_two_wire_display_frame_sender NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = twdfs_pkg::REG_BRIGHTNESS;
        cfg_data = 3'd0;
        for (int i = 0; i < DIGITS; i++)
            digits_held[i] = 8'h00;
        part_now = twdfs_pkg::PART_IDLE;
        phase_now = SEQ_START;
        byte_no = 3'd0;
        step_no = 5'd0;
        shifting = 8'h00;
        clk_pull = 1'b0;
        dio_pull = 1'b0;
        ack_missed = 1'b0;
        bright_reg = 3'd7;
        on_reg = 1'b1;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: store extremes, ignored loads, stray op, idle tick, busy commands
        queue_word(twdfs_pkg::OP_LOAD, 3'd0, 8'hFF, 1'b0);
        queue_word(twdfs_pkg::OP_LOAD, 3'd1, 8'h00, 1'b1);
        queue_word(twdfs_pkg::OP_LOAD, 3'd2, 8'hA5, 1'b0);
        queue_word(twdfs_pkg::OP_LOAD, 3'd3, 8'h5A, 1'b0);
        queue_word(twdfs_pkg::OP_LOAD, 3'd4, 8'h81, 1'b0);
        queue_word(twdfs_pkg::OP_LOAD, 3'd5, 8'h7E, 1'b0);
        queue_word(twdfs_pkg::OP_LOAD, 3'd7, 8'hFF, 1'b1);
        queue_word(OP_UNUSED, 3'd6, 8'hC3, 1'b1);
        queue_word(twdfs_pkg::OP_TICK, 3'd0, 8'h00, 1'b1);
        queue_word(twdfs_pkg::OP_BEGIN, 3'd0, 8'h00, 1'b0);
        queue_word(twdfs_pkg::OP_LOAD, 3'd0, 8'h33, 1'b0);
        queue_word(twdfs_pkg::OP_BEGIN, 3'd2, 8'h00, 1'b0);
        queue_word(OP_UNUSED, 3'd1, 8'h3C, 1'b0);
        // first byte left unacknowledged
        repeat (40)
            queue_word(twdfs_pkg::OP_TICK, 3'd0, 8'h00, 1'b1);
        finish_frame();
        drain();

        write_setting(3'd0, 1'b0);
        send_gap_pct = 24;
        recv_gap_pct = 83;
        random_phase(PHASE_WORDS);
        hold_ask <= hold_ask + 1;
        drain();

        write_setting(3'd7, 1'b1);
        send_gap_pct = 83;
        recv_gap_pct = 24;
        random_phase(PHASE_WORDS);
        hold_ask <= hold_ask + 1;
        drain();

        write_setting(3'd3, 1'b0);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        random_phase(PHASE_WORDS);
        hold_ask <= hold_ask + 1;
        drain();

        write_setting(3'($urandom), 1'($urandom));
        random_phase(PHASE_WORDS);
        drain();

        if (failures == 0)
            $display("tb_two_wire_display_frame_sender OK");
        else
            $display("tb_two_wire_display_frame_sender NOT OK");
        $finish;
    end

endmodule
